/* hdl/slc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier package
// Line class codes, character constants and the structs that pass between
// the classifier, the counter bank and the top level.
// ----------------------------------------------------------------------------
package slc_pkg;

  // Width of every reported count on the result channel.
  localparam int unsigned OUT_WIDTH = 32;

  // Characters that drive the line class.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // What the current line has shown so far.
  typedef enum logic [2:0] {
    LC_EMPTY  = 3'd0,
    LC_SLASH  = 3'd1,
    LC_CODE   = 3'd2,
    LC_SINGLE = 3'd3,
    LC_BLOCK  = 3'd4,
    LC_STAR   = 3'd5,
    LC_CLOSED = 3'd6
  } line_class_t;

  // Outcome of one newline: which counters step.
  typedef struct packed {
    logic line_end;
    logic is_code;
    logic is_comment;
    logic is_empty;
  } line_evt_t;

  // One end-of-file report, already limited to the output width.
  typedef struct packed {
    logic [OUT_WIDTH-1:0] code_lines;
    logic [OUT_WIDTH-1:0] cmt_lines;
    logic [OUT_WIDTH-1:0] blank_lines;
    logic [OUT_WIDTH-1:0] all_lines;
    logic [OUT_WIDTH-1:0] code_total;
    logic [OUT_WIDTH-1:0] total_all_lines;
  } report_t;

endpackage

/* hdl/slc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier input channel
// Valid/ready channel that carries one text byte or an end-of-file mark.
// ----------------------------------------------------------------------------
interface slc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       file_end;

  modport source (output valid, output ch, output file_end, input ready);
  modport sink   (input valid, input ch, input file_end, output ready);
endinterface

/* hdl/slc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier result channel
// Valid/ready channel that carries one per-file line count report.
// ----------------------------------------------------------------------------
interface slc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_lines;
  logic [31:0] cmt_lines;
  logic [31:0] blank_lines;
  logic [31:0] all_lines;
  logic [31:0] code_total;
  logic [31:0] total_all_lines;

  modport source (
    output valid, output code_lines, output cmt_lines, output blank_lines,
    output all_lines, output code_total, output total_all_lines,
    input ready
  );
  modport sink (
    input valid, input code_lines, input cmt_lines, input blank_lines,
    input all_lines, input code_total, input total_all_lines,
    output ready
  );
endinterface

/* hdl/slc_line_class.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier: line class tracker
// Holds the seven-state line class, steps it on each byte and reports what
// kind of line a newline closes.
// ----------------------------------------------------------------------------
module slc_line_class
  import slc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       file_end,
  output line_evt_t  evt
);

  line_class_t class_r;
  line_class_t class_nxt;

  // Next class and newline outcome for the item in the process stage.
  always_comb begin
    class_nxt = class_r;
    evt       = '0;
    if (step) begin
      if (file_end) begin
        class_nxt = LC_EMPTY;
      end else if (ch == CH_NEWLINE) begin
        evt.line_end = 1'b1;
        unique case (class_r) inside
          LC_SLASH: begin
            // A lone slash is counted in no class and carries over.
            class_nxt = LC_SLASH;
          end
          LC_CODE: begin
            evt.is_code = 1'b1;
            class_nxt   = LC_EMPTY;
          end
          LC_SINGLE, LC_CLOSED: begin
            evt.is_comment = 1'b1;
            class_nxt      = LC_EMPTY;
          end
          LC_BLOCK: begin
            evt.is_comment = 1'b1;
            class_nxt      = LC_BLOCK;
          end
          LC_STAR: begin
            evt.is_comment = 1'b1;
            class_nxt      = LC_BLOCK;
          end
          default: begin
            evt.is_empty = 1'b1;
            class_nxt    = LC_EMPTY;
          end
        endcase
      end else begin
        unique case (class_r) inside
          LC_SLASH: begin
            if (ch == CH_SLASH) begin
              class_nxt = LC_SINGLE;
            end else if (ch == CH_STAR) begin
              class_nxt = LC_BLOCK;
            end else begin
              class_nxt = LC_CODE;
            end
          end
          LC_CODE, LC_SINGLE, LC_CLOSED: begin
            class_nxt = class_r;
          end
          LC_BLOCK: begin
            if (ch == CH_STAR) begin
              class_nxt = LC_STAR;
            end
          end
          LC_STAR: begin
            class_nxt = (ch == CH_SLASH) ? LC_CLOSED : LC_BLOCK;
          end
          default: begin
            // Blank characters keep the line empty.
            if (ch == CH_SPACE || ch == CH_LBRACE || ch == CH_RBRACE) begin
              class_nxt = LC_EMPTY;
            end else if (ch == CH_SLASH) begin
              class_nxt = LC_SLASH;
            end else begin
              class_nxt = LC_CODE;
            end
          end
        endcase
      end
    end
  end

  // Class register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r <= LC_EMPTY;
    end else begin
      class_r <= class_nxt;
    end
  end

endmodule

/* hdl/slc_counters.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier: counter bank
// Saturating per-file line counters and running totals, and the end-of-file
// report built from them.
// ----------------------------------------------------------------------------
module slc_counters
  import slc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      file_end,
  input  line_evt_t evt,
  output report_t   report
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic [CW-1:0] code_r,  code_nxt;
  logic [CW-1:0] cmt_r,   cmt_nxt;
  logic [CW-1:0] empty_r, empty_nxt;
  logic [CW-1:0] lines_r, lines_nxt;
  logic [CW-1:0] tot_code_r, tot_code_nxt;
  logic [CW-1:0] tot_lines_r, tot_lines_nxt;
  logic [CW-1:0] tot_code_sum;
  logic [CW-1:0] tot_lines_sum;

  // Increment that stops at the counter maximum.
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Sum of two counts that stops at the counter maximum.
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[CW] ? CNT_MAX : sum[CW-1:0];
  endfunction

  // Limit a count to the output width.
  function automatic logic [OUT_WIDTH-1:0] clamp(input logic [CW-1:0] v);
    logic [CW+OUT_WIDTH-1:0] ext;
    ext = (CW + OUT_WIDTH)'(v);
    clamp = (|ext[CW+OUT_WIDTH-1:OUT_WIDTH]) ? '1 : ext[OUT_WIDTH-1:0];
  endfunction

  assign tot_code_sum  = sat_add(tot_code_r, code_r);
  assign tot_lines_sum = sat_add(tot_lines_r, lines_r);

  // Next counter values.
  always_comb begin
    code_nxt      = code_r;
    cmt_nxt       = cmt_r;
    empty_nxt     = empty_r;
    lines_nxt     = lines_r;
    tot_code_nxt  = tot_code_r;
    tot_lines_nxt = tot_lines_r;
    if (step && file_end) begin
      tot_code_nxt  = tot_code_sum;
      tot_lines_nxt = tot_lines_sum;
      code_nxt      = '0;
      cmt_nxt       = '0;
      empty_nxt     = '0;
      lines_nxt     = '0;
    end else if (evt.line_end) begin
      lines_nxt = sat_inc(lines_r);
      if (evt.is_code) begin
        code_nxt = sat_inc(code_r);
      end
      if (evt.is_comment) begin
        cmt_nxt = sat_inc(cmt_r);
      end
      if (evt.is_empty) begin
        empty_nxt = sat_inc(empty_r);
      end
    end
  end

  // Report for an end-of-file item: per-file counts and updated totals.
  always_comb begin
    report.code_lines      = clamp(code_r);
    report.cmt_lines       = clamp(cmt_r);
    report.blank_lines     = clamp(empty_r);
    report.all_lines       = clamp(lines_r);
    report.code_total      = clamp(tot_code_sum);
    report.total_all_lines = clamp(tot_lines_sum);
  end

  // Counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r      <= '0;
      cmt_r       <= '0;
      empty_r     <= '0;
      lines_r     <= '0;
      tot_code_r  <= '0;
      tot_lines_r <= '0;
    end else begin
      code_r      <= code_nxt;
      cmt_r       <= cmt_nxt;
      empty_r     <= empty_nxt;
      lines_r     <= lines_nxt;
      tot_code_r  <= tot_code_nxt;
      tot_lines_r <= tot_lines_nxt;
    end
  end

endmodule

/* hdl/source_line_classifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier core
// Counts code, comment, empty and all lines of source text streamed one byte
// per transfer, and reports the counts at each end-of-file mark.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one text byte per transfer, or an end-of-file mark
//   (file_end set, ch ignored). out_chan carries one report per end-of-file
//   mark: the per-file code, comment, empty and all-line counts and the
//   running totals of code and all lines. Text bytes produce no transfer.
//   The block takes one input transfer every cycle, except while an end-of-file
//   mark waits in the input register as below. Each item is registered at the
//   input, then classified and counted from there; its end-of-file mark loads
//   a report into the result register, which drives out_chan.
//   When the receiver stalls, the pending report is held in the result
//   register; text bytes keep flowing, and only a second end-of-file mark
//   waits in the input register until the report is taken, holding
//   in_chan.ready low meanwhile.
//   Synchronous reset clears the line class, all counters and both valid
//   flags; the block is ready as soon as reset is released.
//   Counters saturate at COUNT_WIDTH bits; a count above 32 bits is
//   reported as all ones.
// ----------------------------------------------------------------------------
module source_line_classifier_core
  import slc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  slc_in_if.sink           in_chan,
  slc_out_if.source        out_chan
);

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_end_r;

  // Result register.
  logic       out_valid_r;
  report_t    out_rep_r;

  logic       s1_go;
  logic       in_take;
  line_evt_t  evt;
  report_t    report;

  // The item moves on unless it is a report and the result slot is held.
  assign s1_go   = s1_valid_r && (!s1_end_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_take = in_chan.valid && in_chan.ready;

  slc_line_class u_line_class (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .ch       (s1_ch_r),
    .file_end (s1_end_r),
    .evt      (evt)
  );

  slc_counters #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .file_end (s1_end_r),
    .evt      (evt),
    .report   (report)
  );

  // Input stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r  <= in_chan.ch;
      s1_end_r <= in_chan.file_end;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      out_rep_r <= report;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.code_lines      = out_rep_r.code_lines;
  assign out_chan.cmt_lines       = out_rep_r.cmt_lines;
  assign out_chan.blank_lines     = out_rep_r.blank_lines;
  assign out_chan.all_lines       = out_rep_r.all_lines;
  assign out_chan.code_total      = out_rep_r.code_total;
  assign out_chan.total_all_lines = out_rep_r.total_all_lines;

endmodule

/* tb/source_line_classifier_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source line classifier core testbench
// Streams directed and random source text through the classifier, with random
// gaps on the input side and random stalls on the report side. A software
// line tally predicts every end-of-file report, and each report transfer is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module source_line_classifier_core_test
  import slc_pkg::*;
;

  // Line tally: tracks the line class and counters and queues expected reports.
  class line_tally;
    line_class_t cls;
    logic [OUT_WIDTH-1:0] code_n, comment_n, empty_n, line_n;
    logic [OUT_WIDTH-1:0] total_code_n, total_line_n;
    report_t reports_due[$];
    int unsigned mismatches;
    int unsigned reports_seen;
    int unsigned text_bytes;
    int unsigned file_marks;

    function new();
      cls          = LC_EMPTY;
      code_n       = '0;
      comment_n    = '0;
      empty_n      = '0;
      line_n       = '0;
      total_code_n = '0;
      total_line_n = '0;
      mismatches   = 0;
      reports_seen = 0;
      text_bytes   = 0;
      file_marks   = 0;
    endfunction

    // Saturating add at the output width.
    function logic [OUT_WIDTH-1:0] sat_add(logic [OUT_WIDTH-1:0] a,
                                           logic [OUT_WIDTH-1:0] b);
      logic [OUT_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[OUT_WIDTH] ? '1 : sum[OUT_WIDTH-1:0];
    endfunction

    // Updates the tally for one accepted input transfer.
    function void take_item(logic [7:0] ch, logic fe);
      report_t r;
      if (fe) begin
        // End of file: fold into the totals, queue the report, clear the file.
        file_marks++;
        total_code_n = sat_add(total_code_n, code_n);
        total_line_n = sat_add(total_line_n, line_n);
        r.code_lines      = code_n;
        r.cmt_lines       = comment_n;
        r.blank_lines     = empty_n;
        r.all_lines       = line_n;
        r.code_total      = total_code_n;
        r.total_all_lines = total_line_n;
        reports_due.push_back(r);
        code_n    = '0;
        comment_n = '0;
        empty_n   = '0;
        line_n    = '0;
        cls       = LC_EMPTY;
      end else if (ch == CH_NEWLINE) begin
        // Newline closes the line; a lone slash carries over, counted in no class.
        text_bytes++;
        case (cls) inside
          LC_SLASH: ;
          LC_CODE: begin
            code_n = sat_add(code_n, 1);
            cls    = LC_EMPTY;
          end
          LC_SINGLE, LC_CLOSED: begin
            comment_n = sat_add(comment_n, 1);
            cls       = LC_EMPTY;
          end
          LC_BLOCK: comment_n = sat_add(comment_n, 1);
          LC_STAR: begin
            comment_n = sat_add(comment_n, 1);
            cls       = LC_BLOCK;
          end
          default: begin
            empty_n = sat_add(empty_n, 1);
            cls     = LC_EMPTY;
          end
        endcase
        line_n = sat_add(line_n, 1);
      end else begin
        // Ordinary text byte.
        text_bytes++;
        case (cls) inside
          LC_SLASH: begin
            if (ch == CH_SLASH) cls = LC_SINGLE;
            else if (ch == CH_STAR) cls = LC_BLOCK;
            else cls = LC_CODE;
          end
          LC_CODE, LC_SINGLE, LC_CLOSED: ;
          LC_BLOCK: begin
            if (ch == CH_STAR) cls = LC_STAR;
          end
          LC_STAR: begin
            if (ch == CH_SLASH) cls = LC_CLOSED;
            else cls = LC_BLOCK;
          end
          default: begin
            if (ch == CH_SPACE || ch == CH_LBRACE || ch == CH_RBRACE) cls = LC_EMPTY;
            else if (ch == CH_SLASH) cls = LC_SLASH;
            else cls = LC_CODE;
          end
        endcase
      end
    endfunction

    // Compares one report transfer with the oldest expected report.
    function void check_report(report_t got);
      report_t want;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected report: code %0d comment %0d empty %0d all %0d",
                   $time, got.code_lines, got.cmt_lines, got.blank_lines, got.all_lines);
        return;
      end
      want = reports_due.pop_front();
      reports_seen++;
      if (got.code_lines !== want.code_lines ||
          got.cmt_lines !== want.cmt_lines ||
          got.blank_lines !== want.blank_lines ||
          got.all_lines !== want.all_lines ||
          got.code_total !== want.code_total ||
          got.total_all_lines !== want.total_all_lines) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("[%0t] report %0d mismatch (exp/got): code %0d/%0d comment %0d/%0d ",
                 $time, reports_seen, want.code_lines, got.code_lines,
                 want.cmt_lines, got.cmt_lines);
          $display("empty %0d/%0d all %0d/%0d total_code %0d/%0d total_all %0d/%0d",
                   want.blank_lines, got.blank_lines, want.all_lines, got.all_lines,
                   want.code_total, got.code_total,
                   want.total_all_lines, got.total_all_lines);
        end
      end
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned MIN_FILES    = 40;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n;

  line_tally   tally = new();
  bit          no_idle;
  int unsigned items_sent;
  int unsigned idle_cycles = 0;

  slc_in_if  in_chan ();
  slc_out_if out_chan ();

  source_line_classifier_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Blank byte: space or a brace.
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  // Any byte but a newline.
  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
    return b;
  endfunction

  // A byte that starts a code line: not blank, not a slash, not a newline.
  function automatic logic [7:0] pick_code();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_NEWLINE || b == CH_SPACE || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_SLASH);
    return b;
  endfunction

  // Sends one input item after a random gap and waits for its transfer.
  task automatic send_item(input logic [7:0] ch, input logic fe);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.ch       <= ch;
    in_chan.file_end <= fe;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    tally.take_item(ch, fe);
    items_sent++;
  endtask

  // Report side: random stall before each report transfer.
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  // Checks every report transfer.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      tally.check_report({out_chan.code_lines, out_chan.cmt_lines, out_chan.blank_lines,
                          out_chan.all_lines, out_chan.code_total,
                          out_chan.total_all_lines});
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("source_line_classifier_core verification failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned kind;
    int unsigned directed_items;
    items_sent       = 0;
    no_idle          = 1'b0;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.ch       <= 8'h00;
    in_chan.file_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lines, with only a newline and with blanks.
    send_item(CH_NEWLINE, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(CH_LBRACE, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Single-line comment.
    send_item(CH_SLASH, 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // A slash at line end is counted in no class and carries into a block comment.
    send_item(CH_SLASH, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    send_item(CH_STAR, 1'b0);
    // Two stars in a row fall back into the block; the block stays open.
    send_item(CH_STAR, 1'b0);
    send_item(CH_STAR, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Newline right after a star inside the block.
    send_item(CH_STAR, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Close the block.
    send_item(CH_STAR, 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Code line with the top byte value.
    send_item(8'hFF, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Unterminated last line is dropped at the end of the file.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // An open block comment is cleared by the end of the file.
    send_item(CH_SLASH, 1'b0);
    send_item(CH_STAR, 1'b0);
    send_item(8'h00, 1'b1);
    // Empty file.
    send_item(8'h5A, 1'b1);
    directed_items = items_sent;

    // Random: mostly well-formed lines with random content, some noise.
    while (items_sent < directed_items + RANDOM_ITEMS || tally.file_marks < MIN_FILES) begin
      kind = $urandom_range(0, 12);
      case (kind)
        0, 1: begin
          // Blank line.
          repeat ($urandom_range(0, 4)) send_item(pick_blank(), 1'b0);
          send_item(CH_NEWLINE, 1'b0);
        end
        2, 3, 4: begin
          // Code line.
          repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
          send_item(pick_code(), 1'b0);
          repeat ($urandom_range(0, 6)) send_item(pick_text(), 1'b0);
          send_item(CH_NEWLINE, 1'b0);
        end
        5, 6: begin
          // Single-line comment.
          repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
          send_item(CH_SLASH, 1'b0);
          send_item(CH_SLASH, 1'b0);
          repeat ($urandom_range(0, 5)) send_item(pick_text(), 1'b0);
          send_item(CH_NEWLINE, 1'b0);
        end
        7, 8: begin
          // Block comment, possibly over several lines.
          repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
          send_item(CH_SLASH, 1'b0);
          send_item(CH_STAR, 1'b0);
          repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 3))
              0:       send_item(CH_STAR, 1'b0);
              1:       send_item(CH_NEWLINE, 1'b0);
              default: send_item(pick_text(), 1'b0);
            endcase
          end
          if ($urandom_range(0, 4) != 0) begin
            send_item(CH_STAR, 1'b0);
            send_item(CH_SLASH, 1'b0);
          end
          repeat ($urandom_range(0, 2)) send_item(pick_text(), 1'b0);
          send_item(CH_NEWLINE, 1'b0);
        end
        9: begin
          // Noise over the whole byte range.
          repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        10: begin
          // Lone slash at the end of a line.
          send_item(CH_SLASH, 1'b0);
          send_item(CH_NEWLINE, 1'b0);
        end
        default: begin
          // One to three end-of-file marks; pick the idling style for what follows.
          repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b1);
          no_idle = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
    in_chan.valid <= 1'b0;

    // Wait for the outstanding reports, then let the pipeline drain.
    while (tally.reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d text bytes and %0d end-of-file marks.",
             items_sent, tally.text_bytes, tally.file_marks);
    $display("Checked %0d reports over %0d lines in total; %0d mismatches.",
             tally.reports_seen, tally.total_line_n, tally.mismatches);
    if (tally.mismatches == 0 && tally.reports_due.size() == 0)
      $display("source_line_classifier_core verification clean");
    else
      $display("source_line_classifier_core verification failed");
    $finish;
  end

endmodule
